// File: hdl/pngu_pkg.sv
// package: constants, codes, types and helpers for the png unfilter unit
`timescale 1ns / 1ps

package pngu_pkg;

  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  typedef enum logic [1:0] {
    CFG_COLOR_TYPE = 2'd0,
    CFG_WIDTH      = 2'd1,
    CFG_HEIGHT     = 2'd2,
    CFG_PAL_COUNT  = 2'd3
  } cfg_idx_t;

  localparam logic [2:0] CT_GRAY       = 3'd0;
  localparam logic [2:0] CT_RGB        = 3'd2;
  localparam logic [2:0] CT_PALETTE    = 3'd3;
  localparam logic [2:0] CT_GRAY_ALPHA = 3'd4;
  localparam logic [2:0] CT_RGBA       = 3'd6;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  typedef struct packed {
    logic        err;
    logic        emit;
    logic        first;
    logic        row_zero;
    logic        last;
    logic [2:0]  filt;
    logic [1:0]  k;
    logic [11:0] col;
    logic [11:0] row;
  } s1_ctl_t;

  function automatic logic [2:0] bytes_per_pixel(input logic [2:0] ct);
    logic [2:0] n;
    case (ct)
      CT_GRAY, CT_PALETTE: n = 3'd1;
      CT_RGB:              n = 3'd3;
      CT_GRAY_ALPHA:       n = 3'd2;
      CT_RGBA:             n = 3'd4;
      default:             n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] da, db, dc, pa, pb, pc;
    logic [7:0] r;
    da = $signed({3'b0, b}) - $signed({3'b0, c});
    db = $signed({3'b0, a}) - $signed({3'b0, c});
    dc = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({2'b0, c, 1'b0});
    pa = (da < 0) ? -da : da;
    pb = (db < 0) ? -db : db;
    pc = (dc < 0) ? -dc : dc;
    priority if (pa <= pb && pa <= pc) begin
      r = a;
    end else if (pb <= pc) begin
      r = b;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

// File: hdl/png_unfilter_to_rgb_unit.sv
// top level: png scanline unfilter with line store, palette and rgb conversion
//
//  channel   direction  handshake                 contents
//  s_*       in         s_tvalid / s_tready       image byte or palette entry
//  m_*       out        m_tvalid / m_tready       rgb pixel with position or error
//  cfg_*     in         cfg_we                    color type, size, palette count
//
// one input byte per cycle sustained while the output is not stalled; a byte passes a
// line store read stage, an unfilter stage (line store write, palette read) and the
// output register, in that order, before its pixel reaches m_tdata.
// rst is synchronous; memories are not cleared, row 0 reads zeros for the up bytes.
// a stalled output holds the pipeline stage by stage; input stalls only when full.
`timescale 1ns / 1ps

module png_unfilter_to_rgb_unit
  import pngu_pkg::*;
#(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // data_byte, palette_index, pal_red, pal_green, pal_blue
  input  logic        s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // red, green, blue, pixel_col, pixel_row
  output logic        m_tuser,  // status
  output logic        m_tlast,  // last_pixel
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_data
);

  localparam int LINE_DEPTH = MAX_WIDTH * 4;
  localparam int LAW = $clog2(LINE_DEPTH);
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [14:0] MAX_W = 15'(MAX_WIDTH);
  localparam logic [8:0]  PAL_D = 9'(PALETTE_DEPTH);

  logic [2:0]  color_type;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [8:0]  palette_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_type    <= CT_GRAY;
      image_width   <= 13'd1;
      image_height  <= 13'd1;
      palette_count <= 9'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_COLOR_TYPE: color_type    <= cfg_data[2:0];
        CFG_WIDTH:      image_width   <= cfg_data;
        CFG_HEIGHT:     image_height  <= cfg_data;
        CFG_PAL_COUNT:  palette_count <= cfg_data[8:0];
      endcase
    end
  end

  logic [14:0] eff_w;
  logic [12:0] eff_h;
  logic [2:0]  bpp;
  logic [1:0]  bpp_last;

  always_comb begin
    if (image_width == 13'd0) begin
      eff_w = 15'd1;
    end else if ({2'b0, image_width} > MAX_W) begin
      eff_w = MAX_W;
    end else begin
      eff_w = {2'b0, image_width};
    end
    if (image_height == 13'd0) begin
      eff_h = 13'd1;
    end else if (image_height > MAX_HEIGHT) begin
      eff_h = MAX_HEIGHT;
    end else begin
      eff_h = image_height;
    end
    bpp      = bytes_per_pixel(color_type);
    bpp_last = 2'(bpp - 3'd1);
  end

  // pipeline flow
  logic    s1_valid, s2_valid;
  logic    out_load, s2_adv, s1_adv, acc;
  s1_ctl_t s1_ctl, s2_ctl, ctl_new;
  logic    new_valid;

  assign out_load = !m_tvalid || m_tready;
  assign s2_adv   = !s2_valid || out_load;
  assign s1_adv   = !s1_valid || s2_adv;
  assign s_tready = s1_adv;
  assign acc      = s_tvalid && s_tready;

  // stage 0 control
  logic           in_row, in_row_next;
  logic [2:0]     filt, filt_next;
  logic [12:0]    row, row_next;
  logic [CW-1:0]  col, col_next;
  logic [1:0]     kcnt, kcnt_next;
  logic [LAW-1:0] addr, addr_next;
  logic           err_latched, err_latched_next;
  logic           done, done_next;
  logic           col_end, row_end_h;

  assign col_end   = (15'(col) + 15'd1) >= eff_w;
  assign row_end_h = ({1'b0, row} + 14'd1) >= {1'b0, eff_h};

  always_comb begin
    in_row_next      = in_row;
    filt_next        = filt;
    row_next         = row;
    col_next         = col;
    kcnt_next        = kcnt;
    addr_next        = addr;
    err_latched_next = err_latched;
    done_next        = done;
    new_valid        = 1'b0;
    ctl_new          = '0;
    ctl_new.filt     = filt;
    ctl_new.k        = kcnt;
    ctl_new.col      = 12'(col);
    ctl_new.row      = row[11:0];
    ctl_new.first    = (addr == '0);
    ctl_new.row_zero = (row == 13'd0);
    if (acc && !s_tuser) begin
      priority if (err_latched) begin
        new_valid    = 1'b1;
        ctl_new.err  = 1'b1;
        ctl_new.emit = 1'b1;
      end else if (done || bpp == 3'd0) begin
        new_valid = 1'b0;
      end else if (!in_row) begin
        if (s_tdata[7:0] > {5'b0, FLT_PAETH}) begin
          err_latched_next = 1'b1;
          new_valid        = 1'b1;
          ctl_new.err      = 1'b1;
          ctl_new.emit     = 1'b1;
        end else begin
          filt_next   = s_tdata[2:0];
          in_row_next = 1'b1;
          col_next    = '0;
          kcnt_next   = 2'd0;
          addr_next   = '0;
        end
      end else begin
        new_valid    = 1'b1;
        ctl_new.emit = (kcnt == bpp_last);
        ctl_new.last = ctl_new.emit && col_end && row_end_h;
        addr_next    = addr + 1'b1;
        if (ctl_new.emit) begin
          kcnt_next = 2'd0;
          col_next  = col + 1'b1;
          if (col_end) begin
            in_row_next = 1'b0;
            row_next    = row + 13'd1;
            if (row_end_h) begin
              done_next = 1'b1;
            end
          end
        end else begin
          kcnt_next = kcnt + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row      <= 1'b0;
      filt        <= FLT_NONE;
      row         <= '0;
      col         <= '0;
      kcnt        <= '0;
      addr        <= '0;
      err_latched <= 1'b0;
      done        <= 1'b0;
    end else begin
      in_row      <= in_row_next;
      filt        <= filt_next;
      row         <= row_next;
      col         <= col_next;
      kcnt        <= kcnt_next;
      addr        <= addr_next;
      err_latched <= err_latched_next;
      done        <= done_next;
    end
  end

  // line store
  logic [7:0]     line_mem [LINE_DEPTH];
  logic [7:0]     line_rd;
  logic [LAW-1:0] s1_addr;
  logic [7:0]     s1_data;
  logic [7:0]     x;
  logic           s1_move;

  assign s1_move = s1_valid && s2_adv && !s1_ctl.err;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_rd <= line_mem[addr];
      s1_addr <= addr;
      s1_data <= s_tdata[7:0];
      s1_ctl  <= ctl_new;
    end
    if (s1_move) begin
      line_mem[s1_addr] <= x;
    end
  end

  // stage 1: unfilter
  logic [31:0] left_bytes, upper_left_bytes, base_left, base_up;
  logic [23:0] pixel_samples, samples_next;
  logic [7:0]  a, b, c;
  logic [8:0]  avg_sum;
  logic        pal_ok;

  always_comb begin
    base_left = s1_ctl.first ? 32'd0 : left_bytes;
    base_up   = s1_ctl.first ? 32'd0 : upper_left_bytes;
    a         = base_left[{bpp_last, 3'b0} +: 8];
    c         = base_up[{bpp_last, 3'b0} +: 8];
    b         = s1_ctl.row_zero ? 8'd0 : line_rd;
    avg_sum   = {1'b0, a} + {1'b0, b};
    case (s1_ctl.filt)
      FLT_SUB:   x = s1_data + a;
      FLT_UP:    x = s1_data + b;
      FLT_AVG:   x = s1_data + avg_sum[8:1];
      FLT_PAETH: x = s1_data + paeth_pick(a, b, c);
      default:   x = s1_data;
    endcase
    unique case (s1_ctl.k)
      2'd0: samples_next = {pixel_samples[23:8], x};
      2'd1: samples_next = {pixel_samples[23:16], x, pixel_samples[7:0]};
      2'd2: samples_next = {x, pixel_samples[15:0]};
      2'd3: samples_next = pixel_samples;
    endcase
    pal_ok = ({1'b0, samples_next[7:0]} < palette_count) && ({1'b0, samples_next[7:0]} < PAL_D);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_bytes       <= '0;
      upper_left_bytes <= '0;
      pixel_samples    <= '0;
    end else if (s1_move) begin
      left_bytes       <= {base_left[23:0], x};
      upper_left_bytes <= {base_up[23:0], b};
      pixel_samples    <= samples_next;
    end
  end

  // palette
  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [23:0] pal_rd;
  logic [23:0] s2_samples;
  logic        s2_pal_ok;

  always_ff @(posedge clk) begin
    if (acc && s_tuser && ({1'b0, s_tdata[15:8]} < PAL_D)) begin
      pal_mem[s_tdata[8 +: PAW]] <= s_tdata[39:16];
    end
    if (s2_adv && s1_valid) begin
      pal_rd     <= pal_mem[samples_next[PAW-1:0]];
      s2_samples <= samples_next;
      s2_pal_ok  <= pal_ok;
      s2_ctl     <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= new_valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // stage 2: color conversion and output register
  logic [23:0] rgb;

  always_comb begin
    if (color_type == CT_GRAY || color_type == CT_GRAY_ALPHA) begin
      rgb = {3{s2_samples[7:0]}};
    end else if (color_type == CT_PALETTE) begin
      rgb = s2_pal_ok ? pal_rd : 24'd0;
    end else begin
      rgb = s2_samples;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= s2_valid && s2_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (s2_ctl.err) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= {s2_ctl.row, s2_ctl.col, rgb};
        m_tuser <= 1'b0;
        m_tlast <= s2_ctl.last;
      end
    end
  end

`ifndef ASSERT_OFF
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> s1_valid) else $error("input stalled with empty pipeline");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err_latched |=> err_latched) else $error("error flag cleared without reset");

  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast) else $error("error result not zero");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> done) else $error("last pixel before image done");
`endif

endmodule
